[hdl/shutpls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shutter pulse sequencer package
// Shared types and constants for the sequencer core and its top level.
// ----------------------------------------------------------------------------
package shutpls_pkg;

   localparam int unsigned CountWidth = 8;
   localparam int unsigned CsrIndexWidth = 1;

   localparam logic [CsrIndexWidth-1:0] REG_ON_TICKS = 1'd0;
   localparam logic [CsrIndexWidth-1:0] REG_OFF_TICKS = 1'd1;

   localparam logic [CountWidth-1:0] ON_TICKS_RESET = 8'd1;
   localparam logic [CountWidth-1:0] OFF_TICKS_RESET = 8'd3;

   // bridge drive codes: bit 0 open half, bit 1 close half
   localparam logic [1:0] DRIVE_NONE = 2'b00;
   localparam logic [1:0] DRIVE_OPEN = 2'b01;
   localparam logic [1:0] DRIVE_CLOSE = 2'b10;

   typedef struct packed {
      logic drive_open;
      logic drive_close;
      logic open_pending;
      logic close_pending;
      logic is_open;
      logic is_closed;
   } status_type;

endpackage
`default_nettype wire

[hdl/shutpls_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shutter pulse sequencer core
// Holds the request latches, done marks, shared pulse and idle counters, the
// bridge drive and the timing registers. Updates the state once per accepted
// word and the timing registers on CSR writes, and presents the updated status.
// ----------------------------------------------------------------------------
module shutpls_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   step,
   input  wire logic                                   open_button,
   input  wire logic                                   close_button,
   input  wire logic                                   tick,
   input  wire logic                                   csr_wr_en,
   input  wire logic [shutpls_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [shutpls_pkg::CountWidth-1:0]     csr_wdata,
   output shutpls_pkg::status_type                     status_next
);

   logic [shutpls_pkg::CountWidth-1:0] on_ticks_ff;
   logic [shutpls_pkg::CountWidth-1:0] off_ticks_ff;

   logic                               open_req_ff, open_req_in;
   logic                               close_req_ff, close_req_in;
   logic                               opened_ff, opened_in;
   logic                               closed_ff, closed_in;
   logic [shutpls_pkg::CountWidth-1:0] pulse_count_ff, pulse_count_in;
   logic [shutpls_pkg::CountWidth-1:0] idle_count_ff, idle_count_in;
   logic [1:0]                         drive_ff, drive_in;

   logic                               move_done;
   logic [shutpls_pkg::CountWidth-1:0] move_pulse;
   logic [shutpls_pkg::CountWidth-1:0] move_idle;
   logic                               move_drive_keep;
   logic                               open_lat;
   logic                               close_lat;

   // one tick of a move on the shared counters
   always_comb begin
      move_done = 1'b0;
      move_pulse = pulse_count_ff;
      move_idle = idle_count_ff;
      move_drive_keep = 1'b1;
      priority if (pulse_count_ff < on_ticks_ff) begin
         move_pulse = pulse_count_ff + 8'd1;
         move_drive_keep = 1'b0;
      end else if (idle_count_ff < off_ticks_ff) begin
         move_idle = idle_count_ff + 8'd1;
         move_drive_keep = 1'b0;
      end else begin
         move_pulse = '0;
         move_idle = '0;
         move_done = 1'b1;
      end
   end

   always_comb begin
      open_lat = open_req_ff | open_button;
      close_lat = close_req_ff | close_button;
      open_req_in = open_lat;
      close_req_in = close_lat;
      opened_in = opened_ff;
      closed_in = closed_ff;
      pulse_count_in = pulse_count_ff;
      idle_count_in = idle_count_ff;
      drive_in = drive_ff;
      if (tick) begin
         priority if (open_lat) begin
            close_req_in = 1'b0;
            closed_in = 1'b0;
            if (!opened_ff) begin
               pulse_count_in = move_pulse;
               idle_count_in = move_idle;
               if (!move_drive_keep) begin
                  drive_in = (move_pulse != pulse_count_ff) ? shutpls_pkg::DRIVE_OPEN
                                                            : shutpls_pkg::DRIVE_NONE;
               end
               if (move_done) begin
                  open_req_in = 1'b0;
                  opened_in = 1'b1;
               end
            end else begin
               open_req_in = 1'b0;
            end
         end else if (close_lat) begin
            opened_in = 1'b0;
            if (!closed_ff) begin
               pulse_count_in = move_pulse;
               idle_count_in = move_idle;
               if (!move_drive_keep) begin
                  drive_in = (move_pulse != pulse_count_ff) ? shutpls_pkg::DRIVE_CLOSE
                                                            : shutpls_pkg::DRIVE_NONE;
               end
               if (move_done) begin
                  close_req_in = 1'b0;
                  closed_in = 1'b1;
               end
            end else begin
               close_req_in = 1'b0;
            end
         end else begin
            drive_in = drive_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ticks_ff <= shutpls_pkg::ON_TICKS_RESET;
         off_ticks_ff <= shutpls_pkg::OFF_TICKS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            shutpls_pkg::REG_ON_TICKS: on_ticks_ff <= csr_wdata;
            shutpls_pkg::REG_OFF_TICKS: off_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_req_ff <= 1'b0;
         close_req_ff <= 1'b0;
         opened_ff <= 1'b0;
         closed_ff <= 1'b0;
         pulse_count_ff <= '0;
         idle_count_ff <= '0;
         drive_ff <= shutpls_pkg::DRIVE_NONE;
      end else if (step) begin
         open_req_ff <= open_req_in;
         close_req_ff <= close_req_in;
         opened_ff <= opened_in;
         closed_ff <= closed_in;
         pulse_count_ff <= pulse_count_in;
         idle_count_ff <= idle_count_in;
         drive_ff <= drive_in;
      end
   end

   assign status_next.drive_open = drive_in[0];
   assign status_next.drive_close = drive_in[1];
   assign status_next.open_pending = open_req_in;
   assign status_next.close_pending = close_req_in;
   assign status_next.is_open = opened_in;
   assign status_next.is_closed = closed_in;

endmodule
`default_nettype wire

[hdl/shutter_pulse_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shutter pulse sequencer
// Latches open and close requests and pulses an H-bridge half on tick words.
//
// Input channel req_*: one word per sample with the two buttons and the
// tenth-second tick flag. Result channel rsp_*: one word per input word with
// the bridge drive, the pending requests and the open and closed marks as
// they stand after that sample.
// Latency: the result is valid the cycle after the input word is accepted.
// Throughput: one word per cycle unless the receiver stalls; the state update is a single pass from the
// state registers to the result register.
// Stall: req_ready stays high while the result register is empty or is being
// taken; when the receiver holds rsp_ready low the result holds and req_ready
// drops until it is taken.
// Reset: requests, marks, counters and drive clear, the result register is
// empty, on_ticks reads 1 and off_ticks reads 3.
// Config: csr_wr_en writes register csr_index (0 on_ticks, 1 off_ticks).
// ----------------------------------------------------------------------------
module shutter_pulse_sequencer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire logic                                  req_open_button,
   input  wire logic                                  req_close_button,
   input  wire logic                                  req_tick,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      logic                                  rsp_drive_open,
   output      logic                                  rsp_drive_close,
   output      logic                                  rsp_open_pending,
   output      logic                                  rsp_close_pending,
   output      logic                                  rsp_is_open,
   output      logic                                  rsp_is_closed,
   input  wire logic                                  csr_wr_en,
   input  wire logic [shutpls_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [shutpls_pkg::CountWidth-1:0]    csr_wdata
);

   logic                    accept;
   logic                    rsp_valid_ff;
   shutpls_pkg::status_type status_next;
   shutpls_pkg::status_type rsp_data_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;

   shutpls_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .open_button  (req_open_button),
      .close_button (req_close_button),
      .tick         (req_tick),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .status_next  (status_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= status_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive_open = rsp_data_ff.drive_open;
   assign rsp_drive_close = rsp_data_ff.drive_close;
   assign rsp_open_pending = rsp_data_ff.open_pending;
   assign rsp_close_pending = rsp_data_ff.close_pending;
   assign rsp_is_open = rsp_data_ff.is_open;
   assign rsp_is_closed = rsp_data_ff.is_closed;

endmodule
`default_nettype wire

[hdl/shutpls_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shutter pulse sequencer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module shutpls_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_drive_open,
   input wire logic rsp_drive_close,
   input wire logic rsp_open_pending,
   input wire logic rsp_close_pending,
   input wire logic rsp_is_open,
   input wire logic rsp_is_closed
);

   logic [5:0] rsp_word;
   assign rsp_word = {rsp_drive_open, rsp_drive_close, rsp_open_pending,
                      rsp_close_pending, rsp_is_open, rsp_is_closed};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted word produced no result");

   a_one_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_drive_open && rsp_drive_close))
      else $error("both bridge halves driven");

   a_one_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_open && rsp_is_closed))
      else $error("shutter marked open and closed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind shutter_pulse_sequencer shutpls_checker u_shutpls_checker (.*);
`default_nettype wire
